// File: sv/wbdc_pkg.sv
// wbdc_pkg: shared types and codes for the write-back data cache
// no dependencies

package wbdc_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_STORE = 2'd1,
      ACT_WDONE = 2'd2,
      ACT_FILL  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_LOAD    = 3'd0,
      KIND_STORE   = 3'd1,
      KIND_BUSY    = 3'd2,
      KIND_WBWORD  = 3'd3,
      KIND_FILLREQ = 3'd4,
      KIND_CONSOLE = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_INVALID = 2'd0,
      ST_CLEAN   = 2'd1,
      ST_DIRTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MISS_IDLE = 2'd0,
      MISS_WACK = 2'd1,
      MISS_FILL = 2'd2
   } miss_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_WBACK,
      FSM_FILLWR,
      FSM_FINREAD,
      FSM_FINISH,
      FSM_OUT
   } fsm_type;

   localparam logic [1:0]  SIZE_BYTE = 2'd0;
   localparam logic [1:0]  SIZE_HALF = 2'd1;
   localparam logic [31:0] CONSOLE_RESET = 32'h1000_0000;

endpackage

// File: sv/wbdc_ram.sv
// wbdc_ram: generic single-port ram with registered read
// no dependencies

module wbdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/write_back_set_assoc_dcache.sv
// write_back_set_assoc_dcache: set-associative write-back write-allocate data cache
// depends on wbdc_pkg and wbdc_ram
//
// channel  | dir | tdata fields (low bit up)                         | tuser
// req_     | in  | address, store_data, access_size, load_signed,    | action
//          |     | fill_word                                         |
// rsp_     | out | data, line_address                                | kind (tlast = last)
// csr_     | in  | console_address                                   | -
//
// a hit reads tag/status, then data, then presents its result; a dirty miss
// emits 8 writeback words one per cycle while rsp_tready is high, from the
// data ram read port; the last fill word then writes tag and store data.
// one request at a time; the next is taken once the results are gone.
// synchronous reset clears line status through valid bits, the last-used
// ways and the miss state; the memories need no clearing pass.
// rsp_tready low holds the current result and the whole block.

module write_back_set_assoc_dcache
   import wbdc_pkg::*;
#(
   parameter int SET_COUNT  = 32,
   parameter int WAY_COUNT  = 4,
   parameter int LINE_BYTES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // address, store_data, access_size, load_signed, fill_word
   input  logic [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // data, line_address
   output logic [2:0]   rsp_tuser,  // kind
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int OFFW  = $clog2(LINE_BYTES);
   localparam int SETW  = $clog2(SET_COUNT);
   localparam int WAYW  = $clog2(WAY_COUNT);
   localparam int WORDS = LINE_BYTES / 4;
   localparam int WRDW  = $clog2(WORDS);
   localparam int TAGW  = 32 - OFFW - SETW;
   localparam int LINES = SET_COUNT * WAY_COUNT;
   localparam int LINEW = SETW + WAYW;
   localparam int ENTW  = LINEW + WRDW;

   // request fields
   logic [31:0] in_addr, in_sdata, in_fword;
   logic [1:0]  in_size;
   logic        in_sgn;
   action_type  in_act;
   assign in_addr  = req_tdata[31:0];
   assign in_sdata = req_tdata[63:32];
   assign in_size  = req_tdata[65:64];
   assign in_sgn   = req_tdata[66];
   assign in_fword = req_tdata[98:67];
   assign in_act   = action_type'(req_tuser);

   // state registers
   fsm_type         state_ff, state_in;
   logic [31:0]     console_ff;
   miss_type        miss_ff, miss_in;
   logic            pst_ff, pst_in;
   logic [31:0]     paddr_ff, paddr_in, pdata_ff, pdata_in;
   logic [1:0]      psize_ff, psize_in;
   logic            psgn_ff, psgn_in;
   logic [WAYW-1:0] vway_ff, vway_in;
   logic [WRDW:0]   fcnt_ff, fcnt_in;
   logic [WRDW:0]   wbk_ff, wbk_in;
   logic [TAGW-1:0] vtag_ff, vtag_in;
   logic [WAY_COUNT-1:0][1:0] status_ff [SET_COUNT];
   logic [WAYW-1:0] lru_ff [SET_COUNT];
   logic [2:0]      okind_ff, okind_in;
   logic [31:0]     odata_ff, odata_in, oaddr_ff, oaddr_in;
   logic            olast_ff, olast_in;
   logic            hway_ff, hway_in;
   logic [WAYW-1:0] way_ff, way_in;

   // tag and data memories: one tag ram per way, one data ram per byte lane
   logic [TAGW-1:0] tag_rd [WAY_COUNT];
   logic            tag_we [WAY_COUNT];
   logic [SETW-1:0] tag_addr;
   logic [TAGW-1:0] tag_wdata;
   logic [7:0]      dat_rd [4];
   logic [7:0]      dat_wd [4];
   logic            dat_we [4];
   logic [ENTW-1:0] dat_addr [4];

   for (genvar w = 0; w < WAY_COUNT; w++) begin : g_tag
      wbdc_ram #(.WIDTH(TAGW), .DEPTH(SET_COUNT)) u_tag (
         .clock(clock), .wr_en(tag_we[w]), .addr(tag_addr),
         .wr_data(tag_wdata), .rd_data(tag_rd[w]));
   end
   for (genvar b = 0; b < 4; b++) begin : g_dat
      wbdc_ram #(.WIDTH(8), .DEPTH(LINES * WORDS)) u_dat (
         .clock(clock), .wr_en(dat_we[b]), .addr(dat_addr[b]),
         .wr_data(dat_wd[b]), .rd_data(dat_rd[b]));
   end

   // the access being worked on: latched request or pending miss
   logic [31:0]     cur_addr;
   logic [SETW-1:0] cur_set;
   logic [TAGW-1:0] cur_tag;
   assign cur_addr = (state_ff == FSM_FINREAD || state_ff == FSM_FINISH) ? paddr_ff
                                                                          : oaddr_ff;
   assign cur_set  = cur_addr[OFFW +: SETW];
   assign cur_tag  = cur_addr[31 -: TAGW];

   // hit detection on registered tag read
   logic            hit;
   logic [WAYW-1:0] hit_way;
   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (status_ff[cur_set][w] != ST_INVALID && tag_rd[w] == cur_tag) begin
            hit = 1'b1;
            hit_way = WAYW'(w);
         end
      end
   end

   // victim way after last used
   logic [WAYW-1:0] vic;
   always_comb begin
      if (int'(lru_ff[cur_set]) == WAY_COUNT - 1) vic = '0;
      else vic = lru_ff[cur_set] + WAYW'(1);
   end

   // lane addressing with wrap inside the line
   logic [OFFW-1:0] lane_off [4];
   logic [OFFW-1:0] lane_pos [4];
   logic [1:0]      lane_of_byte [4];
   logic [WAYW-1:0] acc_way;
   always_comb begin
      if (state_ff == FSM_LOOKUP) acc_way = hit_way;
      else if (state_ff == FSM_FINREAD || state_ff == FSM_FINISH) acc_way = vway_ff;
      else acc_way = way_ff;
      for (int i = 0; i < 4; i++) begin
         lane_off[i] = cur_addr[OFFW-1:0] + OFFW'(i);
         lane_of_byte[i] = 2'(cur_addr[1:0] + 2'(i));
      end
      // line offset of the access byte that falls in each ram lane
      for (int b = 0; b < 4; b++)
         lane_pos[b] = cur_addr[OFFW-1:0] + OFFW'(2'(2'(b) - cur_addr[1:0]));
   end

   // load assembly from lanes
   logic [31:0] ld_word, ld_val;
   always_comb begin
      for (int i = 0; i < 4; i++) ld_word[8*i +: 8] = dat_rd[lane_of_byte[i]];
      ld_val = ld_word;
      if (psize_ff == SIZE_BYTE) begin
         ld_val = {{24{psgn_ff & ld_word[7]}}, ld_word[7:0]};
      end else if (psize_ff == SIZE_HALF) begin
         ld_val = {{16{psgn_ff & ld_word[15]}}, ld_word[15:0]};
      end
   end

   // memory ports
   logic [2:0] nlanes;
   always_comb begin
      nlanes = (psize_ff == SIZE_BYTE) ? 3'd1 : (psize_ff == SIZE_HALF) ? 3'd2 : 3'd4;
      tag_addr  = (state_ff == FSM_IDLE) ? in_addr[OFFW +: SETW] : cur_set;
      tag_wdata = cur_tag;
      for (int w = 0; w < WAY_COUNT; w++) tag_we[w] = 1'b0;
      for (int b = 0; b < 4; b++) begin
         dat_we[b] = 1'b0;
         dat_wd[b] = in_fword[8*b +: 8];
         dat_addr[b] = {cur_set, acc_way, lane_pos[b][OFFW-1:2]};
      end
      case (state_ff)
         FSM_IDLE: begin
            // fill word goes straight into the victim line
            if (req_tvalid && in_act == ACT_FILL && miss_ff == MISS_FILL) begin
               for (int b = 0; b < 4; b++) begin
                  dat_we[b] = 1'b1;
                  dat_addr[b] = {paddr_ff[OFFW +: SETW], vway_ff, fcnt_ff[WRDW-1:0]};
               end
            end
         end
         FSM_LOOKUP: begin
            if (!hit) begin
               for (int b = 0; b < 4; b++)
                  dat_addr[b] = {cur_set, vic, WRDW'(0)};
            end
         end
         FSM_WBACK: begin
            // advance the read only when the current word leaves
            for (int b = 0; b < 4; b++)
               dat_addr[b] = {paddr_ff[OFFW +: SETW], vway_ff,
                              wbk_ff[WRDW-1:0] + WRDW'(rsp_tready)};
         end
         FSM_FINISH: begin
            for (int w = 0; w < WAY_COUNT; w++) tag_we[w] = (WAYW'(w) == vway_ff);
            if (pst_ff) begin
               for (int i = 0; i < 4; i++) begin
                  if (3'(i) < nlanes) begin
                     dat_we[lane_of_byte[i]] = 1'b1;
                     dat_wd[lane_of_byte[i]] = pdata_ff[8*i +: 8];
                     dat_addr[lane_of_byte[i]] = {cur_set, vway_ff, lane_off[i][OFFW-1:2]};
                  end
               end
            end
         end
         FSM_OUT: begin
            if (hway_ff && pst_ff) begin
               for (int i = 0; i < 4; i++) begin
                  if (3'(i) < nlanes && rsp_tready) begin
                     dat_we[lane_of_byte[i]] = 1'b1;
                     dat_wd[lane_of_byte[i]] = pdata_ff[8*i +: 8];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) begin
               if (in_act == ACT_LOAD || in_act == ACT_STORE) begin
                  if ((in_act == ACT_STORE && in_addr == console_ff) || miss_ff != MISS_IDLE)
                     state_in = FSM_OUT;
                  else state_in = FSM_LOOKUP;
               end else if (in_act == ACT_WDONE) begin
                  if (miss_ff == MISS_WACK) state_in = FSM_OUT;
               end else if (miss_ff == MISS_FILL) begin
                  state_in = FSM_FILLWR;
               end
            end
         end
         FSM_LOOKUP: begin
            if (hit || status_ff[cur_set][vic] != ST_DIRTY) state_in = FSM_OUT;
            else state_in = FSM_WBACK;
         end
         FSM_WBACK:   if (rsp_tready && int'(wbk_ff) == WORDS - 1) state_in = FSM_IDLE;
         FSM_FILLWR:  state_in = (int'(fcnt_ff) == WORDS - 1) ? FSM_FINREAD : FSM_IDLE;
         FSM_FINREAD: state_in = FSM_FINISH;
         FSM_FINISH:  state_in = FSM_OUT;
         FSM_OUT:     if (rsp_tready) state_in = FSM_IDLE;
         default:     state_in = FSM_IDLE;
      endcase
   end

   // datapath and result registers
   always_comb begin
      miss_in = miss_ff;
      pst_in = pst_ff;
      paddr_in = paddr_ff;
      pdata_in = pdata_ff;
      psize_in = psize_ff;
      psgn_in = psgn_ff;
      vway_in = vway_ff;
      fcnt_in = fcnt_ff;
      wbk_in = wbk_ff;
      vtag_in = vtag_ff;
      okind_in = okind_ff;
      odata_in = odata_ff;
      oaddr_in = oaddr_ff;
      olast_in = olast_ff;
      hway_in = 1'b0;
      way_in = way_ff;
      case (state_ff)
         FSM_IDLE: begin
            olast_in = 1'b1;
            odata_in = '0;
            oaddr_in = in_addr;
            if (req_tvalid) begin
               if (in_act == ACT_LOAD || in_act == ACT_STORE) begin
                  if (in_act == ACT_STORE && in_addr == console_ff) begin
                     okind_in = KIND_CONSOLE;
                     odata_in = {24'd0, in_sdata[7:0]};
                  end else if (miss_ff != MISS_IDLE) begin
                     okind_in = KIND_BUSY;
                  end else begin
                     pst_in = (in_act == ACT_STORE);
                     pdata_in = in_sdata;
                     psize_in = in_size;
                     psgn_in = in_sgn;
                  end
               end else if (in_act == ACT_WDONE) begin
                  if (miss_ff == MISS_WACK) begin
                     okind_in = KIND_FILLREQ;
                     oaddr_in = {paddr_ff[31:OFFW], OFFW'(0)};
                     fcnt_in = '0;
                     miss_in = MISS_FILL;
                  end
               end
            end
         end
         FSM_LOOKUP: begin
            if (hit) begin
               way_in = hit_way;
               hway_in = 1'b1;
               okind_in = pst_ff ? KIND_STORE : KIND_LOAD;
            end else begin
               paddr_in = oaddr_ff;
               vway_in = vic;
               vtag_in = tag_rd[vic];
               fcnt_in = '0;
               wbk_in = '0;
               if (status_ff[cur_set][vic] == ST_DIRTY) begin
                  miss_in = MISS_WACK;
               end else begin
                  miss_in = MISS_FILL;
                  okind_in = KIND_FILLREQ;
                  oaddr_in = {oaddr_ff[31:OFFW], OFFW'(0)};
               end
            end
         end
         FSM_WBACK: if (rsp_tready) wbk_in = wbk_ff + (WRDW+1)'(1);
         FSM_FILLWR: fcnt_in = (int'(fcnt_ff) == WORDS - 1) ? '0 : fcnt_ff + (WRDW+1)'(1);
         FSM_FINREAD: way_in = vway_ff;
         FSM_FINISH: begin
            miss_in = MISS_IDLE;
            oaddr_in = paddr_ff;
            okind_in = pst_ff ? KIND_STORE : KIND_LOAD;
            odata_in = pst_ff ? 32'd0 : ld_val;
         end
         FSM_OUT: hway_in = hway_ff && !rsp_tready;
         default: ;
      endcase
   end

   // output mux: writeback words come straight from the data ram
   logic [31:0] wb_word;
   always_comb begin
      for (int b = 0; b < 4; b++) wb_word[8*b +: 8] = dat_rd[b];
      rsp_tvalid = (state_ff == FSM_OUT) || (state_ff == FSM_WBACK);
      rsp_tuser = okind_ff;
      rsp_tdata = {oaddr_ff, odata_ff};
      rsp_tlast = olast_ff;
      if (state_ff == FSM_WBACK) begin
         rsp_tuser = KIND_WBWORD;
         rsp_tdata = {vtag_ff, paddr_ff[OFFW +: SETW], wbk_ff[WRDW-1:0], 2'b00, wb_word};
         rsp_tlast = (int'(wbk_ff) == WORDS - 1);
      end else if (hway_ff && !pst_ff) begin
         rsp_tdata = {oaddr_ff, ld_val};
      end
      req_tready = (state_ff == FSM_IDLE);
   end

   // load of a hit uses the live lane read; sign flag comes from the request
   // (psize/psgn are held until the result leaves)

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         console_ff <= CONSOLE_RESET;
         miss_ff <= MISS_IDLE;
         for (int i = 0; i < SET_COUNT; i++)
            for (int w = 0; w < WAY_COUNT; w++) status_ff[i][w] <= ST_INVALID;
         for (int i = 0; i < SET_COUNT; i++) lru_ff[i] <= '0;
         hway_ff <= 1'b0;
         fcnt_ff <= '0;
         wbk_ff <= '0;
      end else begin
         state_ff <= state_in;
         miss_ff <= miss_in;
         hway_ff <= hway_in;
         fcnt_ff <= fcnt_in;
         wbk_ff <= wbk_in;
         if (csr_wr_en) console_ff <= csr_wr_data;
         if (state_ff == FSM_LOOKUP) begin
            if (hit) begin
               lru_ff[cur_set] <= hit_way;
               if (pst_ff) status_ff[cur_set][hit_way] <= ST_DIRTY;
            end else begin
               status_ff[cur_set][vic] <= ST_INVALID;
            end
         end
         if (state_ff == FSM_FINISH) begin
            lru_ff[cur_set] <= vway_ff;
            status_ff[cur_set][vway_ff] <= pst_ff ? ST_DIRTY : ST_CLEAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      pst_ff <= pst_in;
      paddr_ff <= paddr_in;
      pdata_ff <= pdata_in;
      psize_ff <= psize_in;
      psgn_ff <= psgn_in;
      vway_ff <= vway_in;
      vtag_ff <= vtag_in;
      okind_ff <= okind_in;
      odata_ff <= odata_in;
      oaddr_ff <= oaddr_in;
      olast_ff <= olast_in;
      way_ff <= way_in;
   end

endmodule

// File: tb/tb_write_back_set_assoc_dcache.sv
// tb_write_back_set_assoc_dcache: checks the write-back data cache against its own predictor
// depends on wbdc_pkg and write_back_set_assoc_dcache

module tb_write_back_set_assoc_dcache;
   import wbdc_pkg::*;

   localparam int SETS = 32;
   localparam int WAYS = 4;
   localparam int LBYTES = 32;
   localparam int WPL = LBYTES / 4;

   typedef struct packed {
      action_type  act;
      logic [31:0] addr;
      logic [31:0] sdata;
      logic [1:0]  size;
      logic        sgn;
      logic [31:0] fword;
   } request_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
      logic [31:0] laddr;
      logic        last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0] req_tuser = ACT_LOAD;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 0;
   logic [31:0] csr_wr_data = '0;

   write_back_set_assoc_dcache i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // clock
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state
   logic [31:0] cons_addr;
   logic [21:0] tags [SETS][WAYS];
   status_type  stat [SETS][WAYS];
   logic [7:0]  lines [SETS][WAYS][LBYTES];
   logic [1:0]  mru [SETS];
   miss_type    phase;
   logic        p_store;
   logic [31:0] p_addr, p_data;
   logic [1:0]  p_size;
   logic        p_sgn;
   int          vway, fcnt;

   request_type pending_reqs [$];
   result_type  expected_results [$];
   int errors = 0;
   int send_idle = 12, recv_idle = 64;
   bit hold_send = 0;

   task automatic report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void push_result(kind_type k, logic [31:0] d, logic [31:0] a);
      result_type r;
      r.kind = k; r.data = d; r.laddr = a; r.last = 0;
      expected_results.push_back(r);
   endfunction

   function automatic logic [31:0] read_lanes(int s, int w, logic [31:0] a,
                                              logic [1:0] sz, logic sg);
      logic [31:0] v;
      v = '0;
      for (int i = 3; i >= 0; i--) v = {v[23:0], lines[s][w][(a + i) % LBYTES]};
      if (sz == SIZE_BYTE) v = sg ? {{24{v[7]}}, v[7:0]} : {24'd0, v[7:0]};
      else if (sz == SIZE_HALF) v = sg ? {{16{v[15]}}, v[15:0]} : {16'd0, v[15:0]};
      return v;
   endfunction

   function automatic void write_lanes(int s, int w, logic [31:0] a,
                                       logic [31:0] d, logic [1:0] sz);
      int n;
      n = (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
      for (int i = 0; i < n; i++) lines[s][w][(a + i) % LBYTES] = d[8*i +: 8];
   endfunction

   // works out the results one request causes
   function automatic void predict_access(request_type q);
      int prior_count, s, w;
      logic [31:0] ln, base, wd;
      logic [21:0] tg;
      prior_count = expected_results.size();
      ln = q.addr / LBYTES; s = ln % SETS; tg = 22'(ln / SETS);
      if (q.act == ACT_LOAD || q.act == ACT_STORE) begin
         if (q.act == ACT_STORE && q.addr == cons_addr) begin
            push_result(KIND_CONSOLE, {24'd0, q.sdata[7:0]}, q.addr);
         end else if (phase != MISS_IDLE) begin
            push_result(KIND_BUSY, 0, q.addr);
         end else begin
            for (w = 0; w < WAYS; w++)
               if (stat[s][w] != ST_INVALID && tags[s][w] == tg) break;
            if (w < WAYS) begin
               mru[s] = 2'(w);
               if (q.act == ACT_LOAD) begin
                  push_result(KIND_LOAD, read_lanes(s, w, q.addr, q.size, q.sgn), q.addr);
               end else begin
                  write_lanes(s, w, q.addr, q.sdata, q.size);
                  stat[s][w] = ST_DIRTY;
                  push_result(KIND_STORE, 0, q.addr);
               end
            end else begin
               p_store = (q.act == ACT_STORE); p_addr = q.addr; p_data = q.sdata;
               p_size = q.size; p_sgn = q.sgn;
               vway = (mru[s] + 1) % WAYS; fcnt = 0;
               if (stat[s][vway] == ST_DIRTY) begin
                  base = (tags[s][vway] * SETS + s) * LBYTES;
                  for (int k = 0; k < WPL; k++) begin
                     for (int b = 3; b >= 0; b--) wd = {wd[23:0], lines[s][vway][4*k + b]};
                     push_result(KIND_WBWORD, wd, base + 4*k);
                  end
                  phase = MISS_WACK;
               end else begin
                  push_result(KIND_FILLREQ, 0, ln * LBYTES);
                  phase = MISS_FILL;
               end
               stat[s][vway] = ST_INVALID;
            end
         end
      end else if (q.act == ACT_WDONE) begin
         if (phase == MISS_WACK) begin
            push_result(KIND_FILLREQ, 0, (p_addr / LBYTES) * LBYTES);
            fcnt = 0; phase = MISS_FILL;
         end
      end else if (phase == MISS_FILL) begin
         ln = p_addr / LBYTES; s = ln % SETS;
         for (int b = 0; b < 4; b++) lines[s][vway][4*fcnt + b] = q.fword[8*b +: 8];
         fcnt++;
         if (fcnt >= WPL) begin
            tags[s][vway] = 22'(ln / SETS); mru[s] = 2'(vway);
            if (p_store) begin
               write_lanes(s, vway, p_addr, p_data, p_size);
               stat[s][vway] = ST_DIRTY;
               push_result(KIND_STORE, 0, p_addr);
            end else begin
               stat[s][vway] = ST_CLEAN;
               push_result(KIND_LOAD, read_lanes(s, vway, p_addr, p_size, p_sgn), p_addr);
            end
            phase = MISS_IDLE; fcnt = 0;
         end
      end
      if (expected_results.size() > prior_count)
         expected_results[expected_results.size() - 1].last = 1;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_access(pending_reqs.pop_front());
         if ((!req_tvalid || req_tready)) begin
            if (pending_reqs.size() > (req_tvalid && req_tready ? 0 : 0) && !hold_send
                && $urandom_range(99) >= send_idle) begin
               req_tvalid <= 1;
               req_tuser <= pending_reqs[0].act;
               req_tdata <= 104'({pending_reqs[0].fword, pending_reqs[0].sgn,
                                  pending_reqs[0].size, pending_reqs[0].sdata,
                                  pending_reqs[0].addr});
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report($sformatf("unexpected result kind %0d", rsp_tuser));
            end else begin
               e = expected_results.pop_front();
               if (rsp_tuser != e.kind)
                  report($sformatf("kind %0d, want %0d", rsp_tuser, e.kind));
               if (rsp_tdata[31:0] != e.data)
                  report($sformatf("data %h, want %h", rsp_tdata[31:0], e.data));
               if (rsp_tdata[63:32] != e.laddr)
                  report($sformatf("line address %h, want %h", rsp_tdata[63:32], e.laddr));
               if (rsp_tlast != e.last)
                  report($sformatf("last %0d, want %0d", rsp_tlast, e.last));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // request builders
   function automatic logic [31:0] pick_addr();
      // few tags per set so hits, evictions and write-backs all happen
      logic [31:0] a;
      a = (32'($urandom_range(5)) << 10) | (32'($urandom_range(3)) << 5);
      a = a ^ {27'd0, 5'($urandom)};
      if ($urandom_range(9) == 0) a = $urandom;
      return a;
   endfunction

   task automatic add_req(action_type act, logic [31:0] a, logic [31:0] d,
                          logic [1:0] sz, logic sg, logic [31:0] fw);
      request_type q;
      q.act = act; q.addr = a; q.sdata = d; q.size = sz; q.sgn = sg; q.fword = fw;
      pending_reqs.push_back(q);
   endtask

   task automatic add_fill();
      for (int k = 0; k < WPL; k++)
         add_req(ACT_FILL, $urandom, $urandom, 2'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic add_access();
      action_type act;
      act = $urandom_range(1) ? ACT_STORE : ACT_LOAD;
      add_req(act, pick_addr(), $urandom, 2'($urandom_range(3)), 1'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_console(logic [31:0] v);
      @(posedge clock);
      csr_wr_en <= 1; csr_wr_data <= v; cons_addr = v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // random phase: mostly complete miss sequences, some noise
   task automatic random_phase(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(19);
         if (r < 14) add_access();
         else if (r < 16)
            add_req(ACT_WDONE, $urandom, $urandom, 2'($urandom), 1'($urandom), $urandom);
         else if (r < 18) add_fill();
         else add_req(ACT_STORE, cons_addr, $urandom, 2'($urandom), 1'($urandom), $urandom);
         // follow most accesses with what a memory would send back
         if (r < 14 && $urandom_range(9) < 8) begin
            add_req(ACT_WDONE, $urandom, $urandom, 2'($urandom), 1'($urandom), $urandom);
            add_fill();
         end
      end
   endtask

   // stimulus
   initial begin
      int half_left;
      cons_addr = CONSOLE_RESET;
      foreach (stat[s, w]) stat[s][w] = ST_INVALID;
      foreach (mru[s]) mru[s] = 0;
      phase = MISS_IDLE; fcnt = 0; vway = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: miss fill, hits of every size, signed and unsigned, wrap, busy, console, stray
      add_req(ACT_FILL, 0, 0, 0, 0, 32'hdead_beef);
      add_req(ACT_WDONE, 0, 0, 0, 0, 0);
      add_req(ACT_LOAD, 32'h0000_001f, 0, 2'd2, 0, 0);
      add_req(ACT_LOAD, 32'h0000_0004, 0, 0, 0, 0);
      add_req(ACT_STORE, CONSOLE_RESET, 32'hffff_ffa5, 0, 0, 0);
      for (int k = 0; k < WPL; k++) add_req(ACT_FILL, 0, 0, 0, 0, 32'h8080_ff00 ^ (k * 32'h0101_0101));
      add_req(ACT_LOAD, 32'h0000_001f, 0, 2'd0, 1, 0);
      add_req(ACT_LOAD, 32'h0000_001e, 0, 2'd1, 1, 0);
      add_req(ACT_LOAD, 32'h0000_001d, 0, 2'd3, 0, 0);
      add_req(ACT_STORE, 32'h0000_001e, 32'hffff_ffff, 2'd2, 0, 0);
      add_req(ACT_LOAD, 32'h0000_0001, 0, 2'd1, 0, 0);
      add_req(ACT_STORE, 32'hffff_ffff, 32'h0, 2'd0, 1, 32'hffff_ffff);
      wait_drained();

      write_console(32'hffff_ffff);
      add_req(ACT_STORE, 32'hffff_ffff, 32'h1234_5678, 0, 0, 0);
      random_phase(6);
      wait_drained();

      write_console(32'h0000_0000);
      send_idle = 64; recv_idle = 12;
      random_phase(6);
      // sender holds off until everything has come back
      half_left = pending_reqs.size() / 2;
      while (pending_reqs.size() > half_left) @(posedge clock);
      hold_send = 1;
      while (req_tvalid || expected_results.size() != 0) @(posedge clock);
      hold_send = 0;
      wait_drained();

      write_console(32'h0000_0040);
      send_idle = 0; recv_idle = 0;
      random_phase(6);
      wait_drained();

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
sv/wbdc_pkg.sv
sv/wbdc_ram.sv
sv/write_back_set_assoc_dcache.sv
tb/tb_write_back_set_assoc_dcache.sv
